// ===== rtl/pq_pkg.sv =====
// ----------------------------------------------------------------------------
// pq_pkg
// Shared constants, types and helpers for the stable priority queue.
// ----------------------------------------------------------------------------
package pq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 8;
  localparam int PRIO_W   = 3;
  localparam int STAT_W   = 2;

  localparam logic [PRIO_W-1:0] TOP_PRIO  = PRIO_W'(5);
  localparam logic [PRIO_W-1:0] MIN_PRIO  = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] NONE_PRIO = PRIO_W'(0);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_DEQUEUED = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [VAL_W-1:0] value;
  } res_t;

  // priority 0 maps to 1, 6 and 7 map to 5
  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] q;
    begin
      q = p;
      if (p < MIN_PRIO) begin
        q = MIN_PRIO;
      end else if (p > TOP_PRIO) begin
        q = TOP_PRIO;
      end
      clamp_prio = q;
    end
  endfunction

endpackage

// ===== rtl/pq_store.sv =====
// ----------------------------------------------------------------------------
// pq_store
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pq_store #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pq_ctrl
// Sequencer: handles enqueue at once, scans for the dequeue slot one entry
// per cycle, then closes the gap one entry per cycle.
// ----------------------------------------------------------------------------
module pq_ctrl
  import pq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [VAL_W-1:0]  item_value,
  input  logic [PRIO_W-1:0] item_priority,
  output wr_t               wr,
  output logic [IDX_W-1:0]  rd_addr,
  input  entry_t            rd_data,
  output res_t              res
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [VAL_W-1:0]  best_val_r, best_val_nxt;

  logic              accept;
  logic              hit;
  logic              upd;
  logic [CNT_W-1:0]  idx_plus1;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign idx_plus1 = CNT_W'(idx_r) + CNT_W'(1);
  assign hit       = (rd_data.prio == TOP_PRIO);
  assign upd       = (rd_data.prio > best_prio_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      best_idx_r  <= '0;
      best_prio_r <= NONE_PRIO;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      best_idx_r  <= best_idx_nxt;
      best_prio_r <= best_prio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_val_nxt  = best_val_r;
    wr            = '0;
    // store reads are issued ahead of use; idle keeps slot 0 ready for a scan
    rd_addr       = '0;
    res           = '0;
    res.status    = STAT_ENQUEUED;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res.valid = 1'b1;
          if (opcode == OP_ENQ) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              res.status = STAT_FULL;
            end else begin
              wr.we         = 1'b1;
              wr.addr       = count_r[IDX_W-1:0];
              wr.data.value = item_value;
              wr.data.prio  = clamp_prio(item_priority);
              count_nxt     = count_r + CNT_W'(1);
              res.status    = STAT_ENQUEUED;
            end
          end else if (count_r == '0) begin
            res.status = STAT_EMPTY;
          end else begin
            // dequeue: result comes at the end of the shift pass
            res.valid     = 1'b0;
            idx_nxt       = '0;
            best_idx_nxt  = '0;
            best_prio_nxt = NONE_PRIO;
            state_nxt     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit || upd) begin
          best_idx_nxt  = idx_r;
          best_prio_nxt = rd_data.prio;
          best_val_nxt  = rd_data.value;
        end
        if (hit || (idx_plus1 == count_r)) begin
          idx_nxt   = (hit || upd) ? idx_r : best_idx_r;
          rd_addr   = idx_nxt + IDX_W'(1);
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_nxt;
        end
      end

      S_SHIFT: begin
        // rd_data holds the entry just above idx_r
        rd_addr = idx_r + IDX_W'(2);
        if (idx_plus1 < count_r) begin
          wr.we   = 1'b1;
          wr.addr = idx_r;
          wr.data = rd_data;
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          res.valid  = 1'b1;
          res.status = STAT_DEQUEUED;
          res.value  = best_val_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index past last entry");

  a_shift_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (best_prio_r != NONE_PRIO))
    else $error("shift pass without a chosen entry");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && res.valid) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not remove exactly one entry");

  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> ((state_r == S_IDLE && accept) || (state_r == S_SHIFT)))
    else $error("result outside a transfer or end of shift");

endmodule

// ===== rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue with oldest-first tie break among equal priorities.
// ----------------------------------------------------------------------------
// enqueue, empty and full results appear in the cycle after the transfer
// dequeue: a scan pass over the stored entries, then a shift pass that closes
//   the gap; the result appears in the cycle after the shift pass ends
// enqueues go back to back; a dequeue holds busy through its scan and
//   shift passes; results are a one-cycle strobe since the receiver cannot stall
// synchronous active-low reset empties the queue; stored entries keep contents
module stable_priority_queue
  import pq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [VAL_W-1:0]  in_item_value,
  input  logic [PRIO_W-1:0] in_item_priority,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [VAL_W-1:0]  out_value
);

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  res_t             res;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [VAL_W-1:0] out_value_r;

  pq_store #(
    .DATA_W ($bits(entry_t)),
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (in_opcode),
    .item_value    (in_item_value),
    .item_priority (in_item_priority),
    .wr            (wr),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res           (res)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= res.status;
    out_value_r  <= res.value;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

// ===== tb/pq_result_checker.sv =====
// ----------------------------------------------------------------------------
// pq_result_checker
// Watches the request and response channels of the stable priority queue. It
// keeps its own copy of the queue contents, works out the response of every
// accepted request and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module pq_result_checker
  import pq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_opcode,
  input  logic [VAL_W-1:0]  in_item_value,
  input  logic [PRIO_W-1:0] in_item_priority,
  input  logic              out_valid,
  input  logic [STAT_W-1:0] out_status,
  input  logic [VAL_W-1:0]  out_value,
  output int                error_count,
  output int                pending_count,
  output int                dequeued_count,
  output int                empty_count,
  output int                full_count
);

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
  } pq_answer_t;

  entry_t     held_entries[$];     // oldest entry at index 0
  pq_answer_t awaited_answers[$];
  int         errs    = 0;
  int         n_deq   = 0;
  int         n_empty = 0;
  int         n_full  = 0;

  // applies one request to the local queue copy and returns its response
  function automatic pq_answer_t serve_request(input logic              op,
                                               input logic [VAL_W-1:0]  val,
                                               input logic [PRIO_W-1:0] pr);
    pq_answer_t ans;
    entry_t     e;
    int         best;
    int         i;
    bit         top_hit;
    ans.status = STAT_ENQUEUED;
    ans.value  = '0;
    if (op == OP_ENQ) begin
      if (held_entries.size() >= CAPACITY) begin
        ans.status = STAT_FULL;
      end else begin
        e.value = val;
        if (pr < MIN_PRIO) begin
          e.prio = MIN_PRIO;
        end else if (pr > TOP_PRIO) begin
          e.prio = TOP_PRIO;
        end else begin
          e.prio = pr;
        end
        held_entries.push_back(e);
      end
    end else if (held_entries.size() == 0) begin
      ans.status = STAT_EMPTY;
    end else begin
      // oldest first; a top-priority entry ends the search
      best    = 0;
      top_hit = 1'b0;
      for (i = 0; i < held_entries.size() && !top_hit; i++) begin
        if (held_entries[i].prio == TOP_PRIO) begin
          best    = i;
          top_hit = 1'b1;
        end else if (held_entries[i].prio > held_entries[best].prio) begin
          best = i;
        end
      end
      ans.status = STAT_DEQUEUED;
      ans.value  = held_entries[best].value;
      held_entries.delete(best);
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    pq_answer_t want;
    if (!rst_n) begin
      held_entries.delete();
      awaited_answers.delete();
    end else begin
      // responses never come in the cycle of their transfer, so check first
      if (out_valid === 1'b1) begin
        if (awaited_answers.size() == 0) begin
          errs++;
          $display("%0t: unexpected response, expected none, got status %0d value %0d",
                   $time, out_status, out_value);
        end else begin
          want = awaited_answers.pop_front();
          if (out_status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %s (%0d), got %0d",
                     $time, want.status.name(), want.status, out_status);
          end
          if (out_value !== want.value) begin
            errs++;
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want.value, out_value);
          end
          case (want.status)
            STAT_DEQUEUED: n_deq++;
            STAT_EMPTY:    n_empty++;
            STAT_FULL:     n_full++;
            default:       ;
          endcase
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_answers.push_back(serve_request(in_opcode, in_item_value,
                                                in_item_priority));
      end
    end
    error_count    <= errs;
    pending_count  <= awaited_answers.size();
    dequeued_count <= n_deq;
    empty_count    <= n_empty;
    full_count     <= n_full;
  end

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Drives enqueue and dequeue requests into the stable priority queue with
// random gaps, mixing fill-heavy and drain-heavy stretches so the queue
// runs full and empty many times. A checker beside the block predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import pq_pkg::*;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [VAL_W-1:0]  in_item_value;
  logic [PRIO_W-1:0] in_item_priority;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_value;

  int error_count;
  int pending_count;
  int dequeued_count;
  int empty_count;
  int full_count;
  int requests_sent = 0;
  int cycles        = 0;
  bit no_idle       = 1'b0;

  stable_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_value        (out_value)
  );

  pq_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_value        (out_value),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .dequeued_count   (dequeued_count),
    .empty_count      (empty_count),
    .full_count       (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  // with start still high, so back-to-back requests never drop it
  task automatic send_request(input logic              op,
                              input logic [VAL_W-1:0]  val,
                              input logic [PRIO_W-1:0] pr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start            = 1'b1;
    in_opcode        = op;
    in_item_value    = val;
    in_item_priority = pr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  initial begin
    int          n;
    int          fill_bias;
    logic        op;
    logic [2:0]  pr;
    start            = 1'b0;
    in_opcode        = OP_ENQ;
    in_item_value    = '0;
    in_item_priority = '0;
    rst_n            = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty dequeue, clamped priorities, ties, full queue
    send_request(OP_DEQ, 8'hFF, 3'd7);
    send_request(OP_ENQ, 8'h00, 3'd0);
    send_request(OP_ENQ, 8'hFF, 3'd3);
    send_request(OP_ENQ, 8'h11, 3'd3);
    send_request(OP_ENQ, 8'h22, 3'd7);
    send_request(OP_ENQ, 8'h33, 3'd5);
    send_request(OP_ENQ, 8'h44, 3'd6);
    send_request(OP_ENQ, 8'h55, 3'd2);
    send_request(OP_ENQ, 8'h66, 3'd4);
    for (n = 0; n < 8; n++) begin
      send_request(OP_ENQ, 8'(8'hA0 + n * 5), 3'((n % 5) + 1));
    end
    send_request(OP_ENQ, 8'h77, 3'd5);
    for (n = 0; n < 6; n++) begin
      send_request(OP_DEQ, 8'(n * 37), 3'(n));
    end

    // random: stretches that lean toward filling or draining
    fill_bias = 50;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 32 == 0) begin
        fill_bias = $urandom_range(15, 85);
        no_idle   = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 99) < fill_bias) ? OP_ENQ : OP_DEQ;
      // mostly legal priorities, some out of range to hit the clamp
      if ($urandom_range(0, 4) == 0) begin
        pr = 3'($urandom_range(0, 7));
      end else begin
        pr = 3'($urandom_range(1, 5));
      end
      send_request(op, 8'($urandom_range(0, 255)), pr);
    end
    start = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d dequeues served, %0d on empty, %0d on full",
             requests_sent, dequeued_count, empty_count, full_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
